[rtl/fit_strategy_segment_allocator_assert.svh]
// Assertion macros shared by the segment allocator RTL.
`ifndef FIT_STRATEGY_SEGMENT_ALLOCATOR_ASSERT_SVH
`define FIT_STRATEGY_SEGMENT_ALLOCATOR_ASSERT_SVH

// Check that cons holds in the same cycle as ante.
`define FSSA_ASSERT_IMP(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Check that cons holds in the cycle after ante.
`define FSSA_ASSERT_NXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[rtl/fssa_pkg.sv]
// Shared constants and codes for the segment allocator.
`timescale 1ns / 1ps
`default_nettype none
package fssa_pkg;

	localparam int MAX_SEGMENTS_DEF   = 64;
	localparam int HEAP_ADDR_BITS_DEF = 16;
	localparam int CFG_INDEX_W        = 1;
	localparam int CFG_DATA_W         = 16;

	localparam logic [CFG_DATA_W-1:0] HEAP_SIZE_RESET = 16'hFFFF;

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_NOFIT = 2'd1,
		ST_BAD   = 2'd2,
		ST_FULL  = 2'd3
	} status_t;

	localparam logic [CFG_INDEX_W-1:0] REG_STRATEGY  = 1'b0;
	localparam logic [CFG_INDEX_W-1:0] REG_HEAP_SIZE = 1'b1;

	localparam logic [1:0] STRAT_FIRST = 2'd0;
	localparam logic [1:0] STRAT_NEXT  = 2'd1;
	localparam logic [1:0] STRAT_BEST  = 2'd2;

	localparam logic MODE_ALLOC = 1'b0;
	localparam logic MODE_FREE  = 1'b1;

endpackage
`default_nettype wire

[rtl/fssa_cfg_if.sv]
// Configuration write channel of the segment allocator.
`timescale 1ns / 1ps
`default_nettype none
interface fssa_cfg_if;
	import fssa_pkg::*;
	logic                   valid;
	logic                   ready;
	logic [CFG_INDEX_W-1:0] index;
	logic [CFG_DATA_W-1:0]  data;
	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface
`default_nettype wire

[rtl/fssa_req_if.sv]
// Request channel of the segment allocator.
`timescale 1ns / 1ps
`default_nettype none
interface fssa_req_if #(parameter int AW = 16);
	logic          valid;
	logic          ready;
	logic          mode;
	logic [AW-1:0] alloc_size;
	logic [AW-1:0] free_offset;
	modport source (output valid, mode, alloc_size, free_offset, input ready);
	modport sink (input valid, mode, alloc_size, free_offset, output ready);
endinterface
`default_nettype wire

[rtl/fssa_rsp_if.sv]
// Response channel of the segment allocator.
`timescale 1ns / 1ps
`default_nettype none
interface fssa_rsp_if #(parameter int AW = 16);
	import fssa_pkg::*;
	logic          valid;
	logic          ready;
	status_t       status;
	logic [AW-1:0] granted_offset;
	modport source (output valid, status, granted_offset, input ready);
	modport sink (input valid, status, granted_offset, output ready);
endinterface
`default_nettype wire

[rtl/fit_strategy_segment_allocator.sv]
// Top level of the first, next and best fit heap segment allocator.
//
//   channel | dir  | beat contents
//   --------+------+-------------------------------------------
//   cfg     | in   | index, data (strategy or heap_size)
//   req     | in   | mode, alloc_size, free_offset
//   rsp     | out  | status, granted_offset
//
// One request at a time; req is ready only while idle and no cfg beat is offered.
// The segment table sits in one RAM with one read and one write per cycle:
// the scan reads every entry once, then a split or merge moves the tail one
// entry a cycle. After reset the S_INIT state writes the first table entry.
// A stalled response holds in its register; the next response waits for it.
`timescale 1ns / 1ps
`default_nettype none
`include "fit_strategy_segment_allocator_assert.svh"
module fit_strategy_segment_allocator #(
	parameter int MAX_SEGMENTS   = fssa_pkg::MAX_SEGMENTS_DEF,
	parameter int HEAP_ADDR_BITS = fssa_pkg::HEAP_ADDR_BITS_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	fssa_cfg_if.sink   cfg,
	fssa_req_if.sink   req,
	fssa_rsp_if.source rsp
);
	import fssa_pkg::*;

	localparam int IW = $clog2(MAX_SEGMENTS);
	localparam int CW = $clog2(MAX_SEGMENTS + 1);
	localparam int XW = CW + 1;
	localparam int AW = HEAP_ADDR_BITS;
	localparam int EW = 2 * AW + 1;
	localparam logic [XW-1:0] MAX_X = XW'(MAX_SEGMENTS);

	typedef struct packed {
		logic [AW-1:0] off;
		logic [AW-1:0] size;
		logic          used;
	} entry_t;

	typedef enum logic [3:0] {
		S_INIT, S_IDLE, S_SCAN, S_FETCH, S_DECIDE, S_SHIFT, S_FIX1, S_FIX2, S_RESP
	} state_t;

	state_t          state_q;
	logic [1:0]      strat_q;
	logic [AW-1:0]   heap_q;
	logic [CW-1:0]   count_q;
	logic [IW-1:0]   pos_q;
	logic            mode_q;
	logic [AW-1:0]   req_size_q;
	logic [AW-1:0]   free_off_q;
	logic [XW-1:0]   start_q;
	logic [XW-1:0]   scan_j_q;
	logic            rd_v_s1;
	logic [XW-1:0]   rd_idx_s1;
	logic            found_q;
	logic [XW-1:0]   t_q;
	logic            have_q;
	logic [XW-1:0]   best_q;
	logic [AW-1:0]   bsize_q;
	logic [2:0]      fetch_q;
	entry_t          win_q [3];
	logic            sh_up_q;
	logic [1:0]      sh_delta_q;
	logic [XW-1:0]   sh_rd_q;
	logic [XW-1:0]   sh_left_q;
	logic            sh_v_s1;
	logic [XW-1:0]   sh_src_s1;
	logic            fix1_en_q;
	logic [XW-1:0]   fix1_a_q;
	entry_t          fix1_d_q;
	logic            fix2_en_q;
	logic [XW-1:0]   fix2_a_q;
	entry_t          fix2_d_q;
	status_t         status_q;
	logic [AW-1:0]   grant_q;
	logic            rsp_valid_q;
	status_t         rsp_status_q;
	logic [AW-1:0]   rsp_grant_q;

	logic            ram_we;
	logic [XW-1:0]   ram_waddr;
	entry_t          ram_wdata;
	logic [XW-1:0]   ram_raddr;
	logic [EW-1:0]   ram_rdata;
	entry_t          rd_e;

	logic [XW-1:0]   cnt_x;
	logic [XW-1:0]   scan_sum;
	logic [XW-1:0]   scan_idx;
	logic            rd_fits;
	logic            w0v, w2v;
	logic            pf, nf;
	entry_t          e;
	logic [AW-1:0]   split_off;
	logic [AW-1:0]   rem;

	assign rd_e      = entry_t'(ram_rdata);
	assign cnt_x     = XW'(count_q);
	assign scan_sum  = start_q + scan_j_q;
	assign scan_idx  = (scan_sum >= cnt_x) ? (scan_sum - cnt_x) : scan_sum;
	assign rd_fits   = !rd_e.used && (rd_e.size >= req_size_q);
	assign e         = win_q[1];
	assign w0v       = (t_q != '0);
	assign w2v       = (t_q + XW'(1)) < cnt_x;
	assign pf        = w0v && !win_q[0].used;
	assign nf        = w2v && !win_q[2].used;
	assign split_off = e.off + req_size_q;
	assign rem       = e.size - req_size_q;

	assign cfg.ready = (state_q == S_IDLE);
	assign req.ready = (state_q == S_IDLE) && !cfg.valid;
	assign rsp.valid          = rsp_valid_q;
	assign rsp.status         = rsp_status_q;
	assign rsp.granted_offset = rsp_grant_q;

	// steer the table RAM ports
	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = '0;
		ram_wdata = '0;
		ram_raddr = '0;
		case (state_q)
			S_INIT: begin
				ram_we    = 1'b1;
				ram_wdata = '{off: '0, size: heap_q, used: 1'b0};
			end
			S_IDLE: begin
				if (cfg.valid && (cfg.index == REG_HEAP_SIZE)) begin
					ram_we    = 1'b1;
					ram_wdata = '{off: '0, size: AW'(cfg.data), used: 1'b0};
				end
			end
			S_SCAN: begin
				ram_raddr = scan_idx;
			end
			S_FETCH: begin
				ram_raddr = t_q + XW'(fetch_q) - XW'(1);
			end
			S_SHIFT: begin
				ram_raddr = sh_rd_q;
				ram_we    = sh_v_s1;
				ram_waddr = sh_up_q ? (sh_src_s1 + XW'(1)) : (sh_src_s1 - XW'(sh_delta_q));
				ram_wdata = rd_e;
			end
			S_FIX1: begin
				ram_we    = fix1_en_q;
				ram_waddr = fix1_a_q;
				ram_wdata = fix1_d_q;
			end
			S_FIX2: begin
				ram_we    = fix2_en_q;
				ram_waddr = fix2_a_q;
				ram_wdata = fix2_d_q;
			end
			default: begin
				ram_we = 1'b0;
			end
		endcase
	end

	fssa_ram #(
		.WIDTH(EW),
		.DEPTH(MAX_SEGMENTS)
	) u_table (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr[IW-1:0]),
		.wdata(ram_wdata),
		.raddr(ram_raddr[IW-1:0]),
		.rdata(ram_rdata)
	);

	// sequencer: scan, fetch neighbors, decide, move tail, patch entries, respond
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_INIT;
			strat_q     <= STRAT_FIRST;
			heap_q      <= AW'(HEAP_SIZE_RESET);
			count_q     <= CW'(1);
			pos_q       <= '0;
			rd_v_s1     <= 1'b0;
			sh_v_s1     <= 1'b0;
			rsp_valid_q <= 1'b0;
		end else begin
			rd_v_s1 <= 1'b0;
			sh_v_s1 <= 1'b0;
			if (rsp_valid_q && rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
			case (state_q)
				S_INIT: begin
					state_q <= S_IDLE;
				end
				S_IDLE: begin
					if (cfg.valid) begin
						if (cfg.index == REG_STRATEGY) begin
							strat_q <= cfg.data[1:0];
						end else begin
							heap_q  <= AW'(cfg.data);
							count_q <= CW'(1);
							pos_q   <= '0;
						end
					end else if (req.valid) begin
						mode_q     <= req.mode;
						req_size_q <= req.alloc_size;
						free_off_q <= req.free_offset;
						found_q    <= 1'b0;
						have_q     <= 1'b0;
						scan_j_q   <= '0;
						start_q    <= '0;
						grant_q    <= '0;
						if ((req.mode == MODE_ALLOC) && (req.alloc_size == '0)) begin
							status_q <= ST_BAD;
							state_q  <= S_RESP;
						end else if ((req.mode == MODE_ALLOC) && (strat_q != STRAT_FIRST) &&
								(strat_q != STRAT_NEXT) && (strat_q != STRAT_BEST)) begin
							status_q <= ST_NOFIT;
							state_q  <= S_RESP;
						end else begin
							// clamp the next fit position to the table
							if ((req.mode == MODE_ALLOC) && (strat_q == STRAT_NEXT)) begin
								if (XW'(pos_q) >= cnt_x) begin
									start_q <= cnt_x - XW'(1);
									pos_q   <= IW'(cnt_x - XW'(1));
								end else begin
									start_q <= XW'(pos_q);
								end
							end
							state_q <= S_SCAN;
						end
					end
				end
				S_SCAN: begin
					if (scan_j_q < cnt_x) begin
						scan_j_q  <= scan_j_q + XW'(1);
						rd_v_s1   <= 1'b1;
						rd_idx_s1 <= scan_idx;
					end
					// evaluate the entry read last cycle
					if (rd_v_s1) begin
						if (mode_q == MODE_FREE) begin
							if ((rd_e.off == free_off_q) && !found_q) begin
								found_q <= 1'b1;
								t_q     <= rd_idx_s1;
							end
						end else if (strat_q == STRAT_BEST) begin
							if (rd_fits && (rd_e.size == req_size_q) && !found_q) begin
								found_q <= 1'b1;
								t_q     <= rd_idx_s1;
							end
							if (rd_fits && (!have_q || (rd_e.size < bsize_q))) begin
								have_q  <= 1'b1;
								best_q  <= rd_idx_s1;
								bsize_q <= rd_e.size;
							end
						end else if (rd_fits && !found_q) begin
							found_q <= 1'b1;
							t_q     <= rd_idx_s1;
						end
					end
					if ((scan_j_q == cnt_x) && !rd_v_s1) begin
						fetch_q <= '0;
						if (found_q) begin
							state_q <= S_FETCH;
						end else if (have_q) begin
							t_q     <= best_q;
							state_q <= S_FETCH;
						end else begin
							status_q <= (mode_q == MODE_FREE) ? ST_BAD : ST_NOFIT;
							if ((mode_q == MODE_ALLOC) && (strat_q == STRAT_NEXT)) begin
								pos_q <= IW'(cnt_x - XW'(1));
							end
							state_q <= S_RESP;
						end
					end
				end
				S_FETCH: begin
					fetch_q <= fetch_q + 3'd1;
					if (fetch_q != '0) begin
						win_q[2'(fetch_q - 3'd1)] <= rd_e;
					end
					if (fetch_q == 3'd3) begin
						state_q <= S_DECIDE;
					end
				end
				S_DECIDE: begin
					fix1_en_q  <= 1'b0;
					fix2_en_q  <= 1'b0;
					sh_left_q  <= '0;
					sh_up_q    <= 1'b0;
					sh_delta_q <= 2'd1;
					status_q   <= ST_OK;
					grant_q    <= '0;
					state_q    <= S_SHIFT;
					if (mode_q == MODE_ALLOC) begin
						grant_q <= e.off;
						if (e.size == req_size_q) begin
							fix1_en_q <= 1'b1;
							fix1_a_q  <= t_q;
							fix1_d_q  <= '{off: e.off, size: e.size, used: 1'b1};
							if (strat_q == STRAT_NEXT) begin
								pos_q <= IW'(t_q);
							end
						end else if (cnt_x >= MAX_X) begin
							status_q <= ST_FULL;
							grant_q  <= '0;
							state_q  <= S_RESP;
						end else begin
							// split: used front, free remainder after it
							fix1_en_q <= 1'b1;
							fix1_a_q  <= t_q;
							fix1_d_q  <= '{off: e.off, size: req_size_q, used: 1'b1};
							fix2_en_q <= 1'b1;
							fix2_a_q  <= t_q + XW'(1);
							fix2_d_q  <= '{off: split_off, size: rem, used: 1'b0};
							sh_up_q   <= 1'b1;
							sh_rd_q   <= cnt_x - XW'(1);
							sh_left_q <= cnt_x - t_q - XW'(1);
							count_q   <= count_q + CW'(1);
							if (strat_q == STRAT_NEXT) begin
								pos_q <= IW'(t_q);
							end
						end
					end else if (e.used) begin
						// release and merge with free neighbors
						fix1_en_q <= 1'b1;
						if (pf && nf) begin
							fix1_a_q   <= t_q - XW'(1);
							fix1_d_q   <= '{off: win_q[0].off,
								size: win_q[0].size + e.size + win_q[2].size, used: 1'b0};
							sh_delta_q <= 2'd2;
							sh_rd_q    <= t_q + XW'(2);
							sh_left_q  <= cnt_x - t_q - XW'(2);
							count_q    <= count_q - CW'(2);
						end else if (pf) begin
							fix1_a_q  <= t_q - XW'(1);
							fix1_d_q  <= '{off: win_q[0].off, size: win_q[0].size + e.size,
								used: 1'b0};
							sh_rd_q   <= t_q + XW'(1);
							sh_left_q <= cnt_x - t_q - XW'(1);
							count_q   <= count_q - CW'(1);
						end else if (nf) begin
							fix1_a_q  <= t_q;
							fix1_d_q  <= '{off: e.off, size: e.size + win_q[2].size, used: 1'b0};
							sh_rd_q   <= t_q + XW'(2);
							sh_left_q <= cnt_x - t_q - XW'(2);
							count_q   <= count_q - CW'(1);
						end else begin
							fix1_a_q <= t_q;
							fix1_d_q <= '{off: e.off, size: e.size, used: 1'b0};
						end
					end
				end
				S_SHIFT: begin
					// move one tail entry per cycle
					if (sh_left_q != '0) begin
						sh_v_s1   <= 1'b1;
						sh_src_s1 <= sh_rd_q;
						sh_rd_q   <= sh_up_q ? (sh_rd_q - XW'(1)) : (sh_rd_q + XW'(1));
						sh_left_q <= sh_left_q - XW'(1);
					end else if (!sh_v_s1) begin
						state_q <= S_FIX1;
					end
				end
				S_FIX1: begin
					state_q <= S_FIX2;
				end
				S_FIX2: begin
					state_q <= S_RESP;
				end
				S_RESP: begin
					if (!rsp_valid_q || rsp.ready) begin
						rsp_valid_q  <= 1'b1;
						rsp_status_q <= status_q;
						rsp_grant_q  <= (status_q == ST_OK) ? grant_q : '0;
						state_q      <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	`FSSA_ASSERT_IMP(a_count_range, 1'b1, (count_q != '0) && (cnt_x <= MAX_X), "segment count out of range")
	`FSSA_ASSERT_NXT(a_accept_busy, req.valid && req.ready, state_q != S_IDLE, "request beat not taken up")
	`FSSA_ASSERT_IMP(a_grant_zero, rsp.valid && (rsp.status != ST_OK), rsp.granted_offset == '0, "offset on failed beat")
	`FSSA_ASSERT_IMP(a_shift_dst, (state_q == S_SHIFT) && sh_v_s1, ram_waddr < MAX_X, "tail move beyond table")

endmodule
`default_nettype wire

[rtl/fssa_ram.sv]
// Generic single write, single read RAM with registered read data.
`timescale 1ns / 1ps
`default_nettype none
module fssa_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	// write and registered read
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule
`default_nettype wire

[sim/fit_strategy_segment_allocator_test.sv]
// Self-checking testbench of the segment allocator: directed rows, then random requests.
`timescale 1ns / 1ps
module fit_strategy_segment_allocator_test;
	import fssa_pkg::*;

	localparam int SEGS = MAX_SEGMENTS_DEF;
	localparam int STALL_LIMIT = 6000;

	typedef struct {
		status_t     st;
		logic [15:0] off;
	} grant_t;

	typedef struct {
		logic        mode;
		logic [15:0] size;
		logic [15:0] offset;
		bit          typed;
		status_t     st;
		logic [15:0] off;
	} row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	fssa_cfg_if        cfg_ch ();
	fssa_req_if #(16)  req_ch ();
	fssa_rsp_if #(16)  rsp_ch ();

	fit_strategy_segment_allocator dut (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg_ch),
		.req    (req_ch),
		.rsp    (rsp_ch)
	);

	always #6 clk = ~clk;

	// Shadow copy of the segment table
	logic [15:0] seg_off [SEGS];
	logic [15:0] seg_sz [SEGS];
	bit          seg_used [SEGS];
	int          seg_cnt;
	int          nf_pos;
	logic [1:0]  policy;
	logic [15:0] heap_units;

	grant_t grant_q[$];
	int     live_q[$];
	int     errors = 0;
	int     stall_cycles = 0;
	bit     quiet = 1'b0;
	int     rsp_hold = 0;

	task automatic report(string what, int got, int want);
		errors++;
		$display("mismatch %s: got %0d want %0d at %0t", what, got, want, $realtime);
	endtask

	function automatic void rebuild_table();
		for (int i = 0; i < SEGS; i++) begin
			seg_off[i] = '0;
			seg_sz[i] = '0;
			seg_used[i] = 1'b0;
		end
		seg_sz[0] = heap_units;
		seg_cnt = 1;
		nf_pos = 0;
	endfunction

	// Fold each run of free segments into its first entry
	function automatic void merge_free();
		int i;
		i = 0;
		while (i < seg_cnt) begin
			if (!seg_used[i]) begin
				while (i + 1 < seg_cnt && !seg_used[i + 1]) begin
					seg_sz[i] = seg_sz[i] + seg_sz[i + 1];
					for (int k = i + 1; k + 1 < seg_cnt; k++) begin
						seg_off[k] = seg_off[k + 1];
						seg_sz[k] = seg_sz[k + 1];
						seg_used[k] = seg_used[k + 1];
					end
					seg_cnt--;
				end
			end
			i++;
		end
	endfunction

	// Mark or split entry idx for a grant of want units
	function automatic status_t carve(int idx, logic [15:0] want, ref logic [15:0] granted);
		if (seg_sz[idx] == want) begin
			seg_used[idx] = 1'b1;
			granted = seg_off[idx];
			return ST_OK;
		end
		if (seg_cnt >= SEGS)
			return ST_FULL;
		for (int k = seg_cnt; k > idx + 1; k--) begin
			seg_off[k] = seg_off[k - 1];
			seg_sz[k] = seg_sz[k - 1];
			seg_used[k] = seg_used[k - 1];
		end
		seg_off[idx + 1] = seg_off[idx] + want;
		seg_sz[idx + 1] = seg_sz[idx] - want;
		seg_used[idx + 1] = 1'b0;
		seg_sz[idx] = want;
		seg_used[idx] = 1'b1;
		seg_cnt++;
		granted = seg_off[idx];
		merge_free();
		return ST_OK;
	endfunction

	function automatic bit usable(int i, logic [15:0] want);
		return !seg_used[i] && seg_sz[i] >= want;
	endfunction

	function automatic status_t place(logic [15:0] want, ref logic [15:0] granted);
		int best;
		int i;
		status_t st;
		best = -1;
		if (want == 0)
			return ST_BAD;
		case (policy)
			STRAT_FIRST: begin
				for (i = 0; i < seg_cnt; i++)
					if (usable(i, want))
						return carve(i, want, granted);
				return ST_NOFIT;
			end
			STRAT_NEXT: begin
				if (nf_pos >= seg_cnt)
					nf_pos = seg_cnt - 1;
				for (int j = 0; j < seg_cnt; j++) begin
					i = (nf_pos + j) % seg_cnt;
					if (usable(i, want)) begin
						st = carve(i, want, granted);
						if (st == ST_OK)
							nf_pos = i;
						return st;
					end
				end
				nf_pos = seg_cnt - 1;
				return ST_NOFIT;
			end
			STRAT_BEST: begin
				for (i = 0; i < seg_cnt; i++) begin
					if (!usable(i, want))
						continue;
					if (seg_sz[i] == want)
						return carve(i, want, granted);
					if (best < 0 || seg_sz[i] < seg_sz[best])
						best = i;
				end
				if (best >= 0)
					return carve(best, want, granted);
				return ST_NOFIT;
			end
			default: return ST_NOFIT;
		endcase
	endfunction

	function automatic grant_t serve(logic mode, logic [15:0] size, logic [15:0] offset);
		grant_t g;
		logic [15:0] granted;
		granted = '0;
		g.st = ST_BAD;
		if (mode == MODE_ALLOC) begin
			g.st = place(size, granted);
			if (g.st == ST_OK)
				live_q.push_back(int'(granted));
		end else begin
			for (int i = 0; i < seg_cnt; i++) begin
				if (seg_off[i] == offset) begin
					seg_used[i] = 1'b0;
					merge_free();
					g.st = ST_OK;
					break;
				end
			end
		end
		g.off = (g.st == ST_OK) ? granted : 16'd0;
		return g;
	endfunction

	// Send one request beat, optionally after an idle burst
	task automatic send(logic mode, logic [15:0] size, logic [15:0] offset,
			bit typed = 1'b0, status_t st = ST_OK, logic [15:0] off = '0);
		int gap;
		grant_t g;
		gap = (!quiet && $urandom_range(0, 3) == 0) ? $urandom_range(1, 19) : 0;
		if (gap > 0) begin
			req_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req_ch.valid <= 1'b1;
		req_ch.mode <= mode;
		req_ch.alloc_size <= size;
		req_ch.free_offset <= offset;
		do @(posedge clk); while (!req_ch.ready);
		g = serve(mode, size, offset);
		if (typed) begin
			g.st = st;
			g.off = off;
		end
		grant_q.push_back(g);
	endtask

	// Drain, then write one register
	task automatic write_reg(logic [CFG_INDEX_W-1:0] index, logic [15:0] value);
		req_ch.valid <= 1'b0;
		wait (grant_q.size() == 0);
		repeat (8) @(posedge clk);
		cfg_ch.valid <= 1'b1;
		cfg_ch.index <= index;
		cfg_ch.data <= value;
		do @(posedge clk); while (!cfg_ch.ready);
		cfg_ch.valid <= 1'b0;
		if (index == REG_STRATEGY) begin
			policy = value[1:0];
		end else begin
			heap_units = value;
			rebuild_table();
			live_q.delete();
		end
	endtask

	task automatic random_phase(int count);
		int pick;
		logic [15:0] size;
		for (int n = 0; n < count; n++) begin
			pick = $urandom_range(0, 99);
			if (pick < 50) begin
				size = (pick < 5) ? 16'($urandom) :
					(pick < 7) ? 16'd0 : 16'($urandom_range(1, heap_units / 6 + 1));
				send(MODE_ALLOC, size, 16'($urandom));
			end else if (pick < 90 && live_q.size() > 0) begin
				pick = $urandom_range(0, live_q.size() - 1);
				send(MODE_FREE, 16'($urandom), 16'(live_q[pick]));
				live_q.delete(pick);
			end else begin
				send(MODE_FREE, 16'($urandom), 16'($urandom));
			end
		end
	endtask

	// Response side: random stall bursts
	always @(posedge clk) begin
		if (rsp_hold > 0) begin
			rsp_hold <= rsp_hold - 1;
			rsp_ch.ready <= 1'b0;
		end else if (!quiet && $urandom_range(0, 5) == 0) begin
			rsp_hold <= $urandom_range(0, 18);
			rsp_ch.ready <= 1'b0;
		end else begin
			rsp_ch.ready <= 1'b1;
		end
	end

	// Compare each response beat with the oldest grant waiting
	always @(posedge clk) begin
		grant_t want;
		if (arst_n && rsp_ch.valid && rsp_ch.ready) begin
			if (grant_q.size() == 0) begin
				report("unexpected response", rsp_ch.status, 0);
			end else begin
				want = grant_q.pop_front();
				if (rsp_ch.status !== want.st)
					report("status", rsp_ch.status, want.st);
				if (rsp_ch.granted_offset !== want.off)
					report("granted_offset", rsp_ch.granted_offset, want.off);
			end
		end
	end

	// Watchdog on cycles with no beat on any channel
	always @(posedge clk) begin
		if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)
				|| (cfg_ch.valid && cfg_ch.ready) || !arst_n) begin
			stall_cycles <= 0;
		end else if (stall_cycles >= STALL_LIMIT) begin
			$display("CHECK FAILED");
			$finish;
		end else begin
			stall_cycles <= stall_cycles + 1;
		end
	end

	row_t rows [] = '{
		'{MODE_ALLOC, 16'd0,     16'd0,     1'b1, ST_BAD,   16'd0},
		'{MODE_ALLOC, 16'hFFFF,  16'hFFFF,  1'b1, ST_OK,    16'd0},
		'{MODE_ALLOC, 16'd1,     16'd0,     1'b1, ST_NOFIT, 16'd0},
		'{MODE_FREE,  16'hFFFF,  16'd0,     1'b1, ST_OK,    16'd0},
		'{MODE_FREE,  16'd0,     16'd0,     1'b1, ST_OK,    16'd0},
		'{MODE_FREE,  16'd0,     16'd5,     1'b1, ST_BAD,   16'd0},
		'{MODE_ALLOC, 16'd100,   16'd0,     1'b1, ST_OK,    16'd0},
		'{MODE_ALLOC, 16'd200,   16'd0,     1'b1, ST_OK,    16'd100},
		'{MODE_ALLOC, 16'd50,    16'd0,     1'b0, ST_OK,    16'd0},
		'{MODE_FREE,  16'd0,     16'd100,   1'b0, ST_OK,    16'd0},
		'{MODE_FREE,  16'd0,     16'd100,   1'b0, ST_OK,    16'd0},
		'{MODE_ALLOC, 16'd150,   16'd0,     1'b0, ST_OK,    16'd0},
		'{MODE_ALLOC, 16'hFFFF,  16'd0,     1'b0, ST_OK,    16'd0},
		'{MODE_FREE,  16'hFFFF,  16'hFFFF,  1'b0, ST_OK,    16'd0},
		'{MODE_ALLOC, 16'hAAAA,  16'h5555,  1'b0, ST_OK,    16'd0},
		'{MODE_ALLOC, 16'h5555,  16'hAAAA,  1'b0, ST_OK,    16'd0}
	};

	initial begin
		cfg_ch.valid = 1'b0;
		cfg_ch.index = '0;
		cfg_ch.data = '0;
		req_ch.valid = 1'b0;
		req_ch.mode = MODE_ALLOC;
		req_ch.alloc_size = '0;
		req_ch.free_offset = '0;
		rsp_ch.ready = 1'b0;
		policy = STRAT_FIRST;
		heap_units = HEAP_SIZE_RESET;
		rebuild_table();
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		repeat (4) @(posedge clk);

		// Directed rows at reset settings
		foreach (rows[i])
			send(rows[i].mode, rows[i].size, rows[i].offset,
				rows[i].typed, rows[i].st, rows[i].off);

		// Undefined policy and the smallest heaps
		write_reg(REG_STRATEGY, 16'd3);
		send(MODE_ALLOC, 16'd1, 16'd0, 1'b1, ST_NOFIT, 16'd0);
		write_reg(REG_STRATEGY, 16'(STRAT_FIRST));
		write_reg(REG_HEAP_SIZE, 16'd0);
		send(MODE_ALLOC, 16'd1, 16'd0, 1'b1, ST_NOFIT, 16'd0);
		write_reg(REG_HEAP_SIZE, 16'd1);
		send(MODE_ALLOC, 16'd1, 16'd0, 1'b1, ST_OK, 16'd0);
		send(MODE_ALLOC, 16'd1, 16'd0, 1'b1, ST_NOFIT, 16'd0);

		// Fill the table with unit grants until a split is refused
		write_reg(REG_HEAP_SIZE, 16'd200);
		for (int n = 0; n < 66; n++)
			send(MODE_ALLOC, 16'd1, 16'd0);

		// Fragment the full table under each policy
		for (int p = 0; p < 3; p++) begin
			write_reg(REG_STRATEGY, 16'(p));
			random_phase(40);
		end

		// Random phases across policies and heap sizes
		for (int ph = 0; ph < 9; ph++) begin
			if (ph == 7)
				quiet = 1'b1;
			write_reg(REG_STRATEGY, 16'(ph % 3));
			write_reg(REG_HEAP_SIZE, (ph == 0) ? 16'hFFFF : (ph == 4) ? 16'd2 :
				16'($urandom_range(64, 4000)));
			random_phase(80);
		end

		req_ch.valid <= 1'b0;
		wait (grant_q.size() == 0);
		repeat (200) @(posedge clk);
		if (errors == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end
endmodule
